/* rtl/core/ptl_pkg.sv */
// Package for the primitive-to-triangle-list core.
// Holds the payload structs, mode codes, sizing constants and corner helpers.
// No dependencies.
`default_nettype none

package ptl_pkg;

    // Significant bits of a vertex index (8..32)
    localparam int INDEX_WIDTH = 32;
    localparam int CORNER_WIDTH = 32;

    // Triangle queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_TRIANGLES = 3'd0,
        MODE_STRIP     = 3'd1,
        MODE_FAN       = 3'd2,
        MODE_POLYGON   = 3'd3,
        MODE_QUADS     = 3'd4,
        MODE_QUAD_STRIP = 3'd5
    } t_mode;

    typedef struct packed {
        logic [31:0] vertex_index;
        logic        end_of_set;
    } t_in_item;

    typedef struct packed {
        logic [CORNER_WIDTH-1:0] corner_a;
        logic [CORNER_WIDTH-1:0] corner_b;
        logic [CORNER_WIDTH-1:0] corner_c;
        logic                    last_of_run;
    } t_tri;

    // Triangles produced by one index
    typedef struct packed {
        logic [1:0] tri_count;
        t_tri       first_tri;
        t_tri       second_tri;
    } t_asm_out;

    function automatic logic [CORNER_WIDTH-1:0] widen_index(
        input logic [INDEX_WIDTH-1:0] idx
    );
        logic [CORNER_WIDTH-1:0] w;
        w = '0;
        w[INDEX_WIDTH-1:0] = idx;
        return w;
    endfunction

    function automatic t_tri make_tri(
        input logic [INDEX_WIDTH-1:0] a,
        input logic [INDEX_WIDTH-1:0] b,
        input logic [INDEX_WIDTH-1:0] c
    );
        t_tri t;
        t.corner_a    = widen_index(a);
        t.corner_b    = widen_index(b);
        t.corner_c    = widen_index(c);
        t.last_of_run = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/primitive_to_triangle_list_core.sv */
// Top level of the primitive-to-triangle-list core.
// Instantiates ptl_assembler and ptl_tri_queue; depends on ptl_pkg.
//
//   channel | direction | handshake                        | payload
//   --------+-----------+----------------------------------+----------------------
//   in      | sink      | i_in_valid / o_in_ready          | i_in_item (t_in_item)
//   out     | source    | o_out_valid / i_out_ready        | o_out_item (t_tri)
//   cfg     | sink      | i_cfg_we (write, no wait)        | i_cfg_data (prim_mode)
//
// One index is taken per cycle while the queue has room; an index waits in the input
// register until the assembler takes it, and its triangles are written to the queue.
// Quads and quad strips give two triangles on every fourth or second index; the
// four-entry triangle queue absorbs them and drains one triangle per cycle while the output is ready.
// Synchronous active-low reset clears the mode to triangle list and empties the queue.
// o_in_ready drops only while the queue holds more than two triangles with an
// index waiting in the input register, i.e. while the output side stalls.
`default_nettype none

module primitive_to_triangle_list_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire ptl_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output ptl_pkg::t_tri          o_out_item,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_data
);
    import ptl_pkg::*;

    logic                   r_in_valid;
    t_in_item               r_in_item;
    logic                   go;
    logic [QUEUE_CNT_W-1:0] queue_count;
    t_asm_out               asm_out;

    // Advance the held index once the queue can take two more triangles
    assign go         = r_in_valid && (queue_count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign o_in_ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the payload until it is consumed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in_item <= i_in_item;
    end

    ptl_assembler u_assembler (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_go       (go),
        .i_item     (r_in_item),
        .o_asm      (asm_out)
    );

    ptl_tri_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_asm   (asm_out),
        .o_count (queue_count),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* rtl/core/ptl_assembler.sv */
// Primitive assembler: mode register, held indices and triangle generation.
// Depends on ptl_pkg.
`default_nettype none

module ptl_assembler (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_data,
    input  wire logic              i_go,
    input  wire ptl_pkg::t_in_item i_item,
    output ptl_pkg::t_asm_out      o_asm
);
    import ptl_pkg::*;

    t_mode                  r_mode;
    logic [1:0]             r_phase, n_phase;
    logic                   r_parity, n_parity;
    logic [INDEX_WIDTH-1:0] r_pivot, n_pivot;
    logic [INDEX_WIDTH-1:0] r_held [3];
    logic [INDEX_WIDTH-1:0] n_held [3];
    logic [INDEX_WIDTH-1:0] v;

    assign v = i_item.vertex_index[INDEX_WIDTH-1:0];

    always_comb begin
        n_phase  = r_phase;
        n_parity = r_parity;
        n_pivot  = r_pivot;
        for (int i = 0; i < 3; i++) begin
            n_held[i] = r_held[i];
        end
        o_asm = '0;

        if (i_go) begin
            case (r_mode)
                MODE_TRIANGLES: begin
                    if (r_phase >= 2'd2) begin
                        o_asm.first_tri = make_tri(r_held[0], r_held[1], v);
                        o_asm.tri_count = 2'd1;
                        n_phase = 2'd0;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_phase == 2'(i)) n_held[i] = v;
                        end
                        n_phase = r_phase + 2'd1;
                    end
                end
                MODE_STRIP: begin
                    if (r_phase >= 2'd2) begin
                        // odd triangles swap their first two corners
                        if (r_parity) begin
                            o_asm.first_tri = make_tri(r_held[1], r_held[0], v);
                        end else begin
                            o_asm.first_tri = make_tri(r_held[0], r_held[1], v);
                        end
                        o_asm.tri_count = 2'd1;
                        n_parity  = ~r_parity;
                        n_held[0] = r_held[1];
                        n_held[1] = v;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_phase == 2'(i)) n_held[i] = v;
                        end
                        n_phase = r_phase + 2'd1;
                    end
                end
                MODE_FAN, MODE_POLYGON: begin
                    if (r_phase == 2'd0) begin
                        n_pivot = v;
                        n_phase = 2'd1;
                    end else if (r_phase == 2'd1) begin
                        n_held[0] = v;
                        n_phase   = 2'd2;
                    end else begin
                        o_asm.first_tri = make_tri(r_pivot, r_held[0], v);
                        o_asm.tri_count = 2'd1;
                        n_held[0] = v;
                    end
                end
                MODE_QUADS: begin
                    if (r_phase == 2'd3) begin
                        o_asm.first_tri  = make_tri(r_held[0], r_held[1], r_held[2]);
                        o_asm.second_tri = make_tri(r_held[0], r_held[2], v);
                        o_asm.tri_count  = 2'd2;
                        n_phase = 2'd0;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_phase == 2'(i)) n_held[i] = v;
                        end
                        n_phase = r_phase + 2'd1;
                    end
                end
                MODE_QUAD_STRIP: begin
                    if (r_phase == 2'd3) begin
                        o_asm.first_tri  = make_tri(r_held[0], r_held[1], v);
                        o_asm.second_tri = make_tri(r_held[0], v, r_held[2]);
                        o_asm.tri_count  = 2'd2;
                        n_held[0] = r_held[2];
                        n_held[1] = v;
                        n_phase   = 2'd2;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            if (r_phase == 2'(i)) n_held[i] = v;
                        end
                        n_phase = r_phase + 2'd1;
                    end
                end
                default: begin
                    // unknown mode: no triangles
                end
            endcase

            // flag the final triangle of this index
            if (o_asm.tri_count == 2'd1) o_asm.first_tri.last_of_run = 1'b1;
            if (o_asm.tri_count == 2'd2) o_asm.second_tri.last_of_run = 1'b1;

            if (i_item.end_of_set) begin
                n_phase  = 2'd0;
                n_parity = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_TRIANGLES;
            r_phase  <= 2'd0;
            r_parity <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode   <= t_mode'(i_cfg_data);
            r_phase  <= 2'd0;
            r_parity <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_parity <= n_parity;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pivot <= n_pivot;
        for (int i = 0; i < 3; i++) begin
            r_held[i] <= n_held[i];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ptl_tri_queue.sv */
// Triangle queue: small register FIFO taking up to two triangles per cycle.
// Depends on ptl_pkg.
`default_nettype none

module ptl_tri_queue (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ptl_pkg::t_asm_out          i_asm,
    output logic [ptl_pkg::QUEUE_CNT_W-1:0] o_count,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output ptl_pkg::t_tri                   o_item
);
    import ptl_pkg::*;

    t_tri                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    logic                   pop;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;

    assign o_count     = r_count;
    assign o_valid     = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];
    assign pop         = o_valid && i_ready;
    assign wr_ptr_next = r_wr_ptr + QUEUE_PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_PTR_W'(i_asm.tri_count);
        n_rd_ptr = r_rd_ptr + QUEUE_PTR_W'(pop);
        n_count  = r_count + QUEUE_CNT_W'(i_asm.tri_count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_asm.tri_count != 2'd0) r_mem[r_wr_ptr] <= i_asm.first_tri;
        if (i_asm.tri_count == 2'd2) r_mem[wr_ptr_next] <= i_asm.second_tri;
    end

endmodule

`default_nettype wire

/* rtl/core/ptl_checker.sv */
// Port-level checker for primitive_to_triangle_list_core, bound to the top level.
// Depends on ptl_pkg.
`default_nettype none

module ptl_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire ptl_pkg::t_in_item i_in_item,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire ptl_pkg::t_tri     o_out_item,
    input wire logic              i_cfg_we,
    input wire logic [2:0]        i_cfg_data
);

    // A stalled triangle holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output triangle changed while stalled");

    // Reset leaves the queue empty and the input open
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

    // Backpressure on the input only comes from a pending triangle
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no triangle pending");

    // An empty block that sees no input transfer stays empty
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && o_in_ready)
        ##1 !o_out_valid && !(i_in_valid && o_in_ready)
        |=> !o_out_valid)
        else $error("triangle appeared without an index");

endmodule

bind primitive_to_triangle_list_core ptl_checker u_ptl_checker (.*);

`default_nettype wire

/* tb/tb_primitive_to_triangle_list_core.sv */
// Self-checking testbench for primitive_to_triangle_list_core: index stream in, triangles out.
// Predicts every triangle from its own model of the assembler and checks each output transfer.
// Depends on ptl_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_primitive_to_triangle_list_core;
    import ptl_pkg::*;

    // Codes 6 and 7 are not in t_mode; the core must treat them as "emit nothing"
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int PIPE_SETTLE  = 4;     // an index passes the input register, then the triangle queue, on its way out
    localparam int END_SETTLE   = 8;
    localparam int STALL_LIMIT  = 1000;  // cycles without any transfer before giving up
    localparam int RANDOM_ITEMS = 420;
    localparam int CALM_AFTER   = 370;   // idling stops once this many random items are queued

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_in_item i_in_item = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_tri     o_out_item;
    logic     i_cfg_we = 1'b0;
    logic [2:0] i_cfg_data = '0;

    primitive_to_triangle_list_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Index stream waiting to be driven, and triangles still owed by the core
    t_in_item pending_idx_q[$];
    t_tri     tri_expect_q[$];

    int issued_count   = 0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;

    // Idling knobs, changed per phase by the stimulus
    int  drv_idle_pct  = 0;
    int  rcv_stall_pct = 0;
    bit  calm          = 1'b0;
    int  drv_gap       = 0;
    int  rcv_gap       = 0;

    // Assembler model state
    logic [2:0]  asm_mode   = MODE_TRIANGLES;
    logic [31:0] pivot_idx  = '0;
    logic [31:0] held_idx [3] = '{default: '0};
    logic [1:0]  asm_phase  = '0;
    logic        strip_odd  = 1'b0;

    function automatic t_tri corners(input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] c);
        t_tri t;
        t.corner_a    = a;
        t.corner_b    = b;
        t.corner_c    = c;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    // Advance the assembler model by one index and queue the triangles it yields
    task automatic predict_triangles(input t_in_item it);
        logic [31:0] v;
        t_tri        tris [2];
        int          n;
        v = '0;
        v[INDEX_WIDTH-1:0] = it.vertex_index[INDEX_WIDTH-1:0];
        n = 0;
        case (asm_mode)
            MODE_TRIANGLES: begin
                if (asm_phase >= 2) begin
                    tris[n] = corners(held_idx[0], held_idx[1], v);
                    n = n + 1;
                    asm_phase = 0;
                end else begin
                    held_idx[asm_phase] = v;
                    asm_phase++;
                end
            end
            MODE_STRIP: begin
                if (asm_phase >= 2) begin
                    // odd triangles swap their first two corners to keep winding
                    if (strip_odd)
                        tris[n] = corners(held_idx[1], held_idx[0], v);
                    else
                        tris[n] = corners(held_idx[0], held_idx[1], v);
                    n = n + 1;
                    strip_odd   = ~strip_odd;
                    held_idx[0] = held_idx[1];
                    held_idx[1] = v;
                end else begin
                    held_idx[asm_phase] = v;
                    asm_phase++;
                end
            end
            MODE_FAN, MODE_POLYGON: begin
                if (asm_phase == 0) begin
                    pivot_idx = v;
                    asm_phase = 1;
                end else if (asm_phase == 1) begin
                    held_idx[0] = v;
                    asm_phase   = 2;
                end else begin
                    tris[n]     = corners(pivot_idx, held_idx[0], v);
                    n = n + 1;
                    held_idx[0] = v;
                end
            end
            MODE_QUADS: begin
                if (asm_phase == 3) begin
                    tris[0]   = corners(held_idx[0], held_idx[1], held_idx[2]);
                    tris[1]   = corners(held_idx[0], held_idx[2], v);
                    n = 2;
                    asm_phase = 0;
                end else begin
                    held_idx[asm_phase] = v;
                    asm_phase++;
                end
            end
            MODE_QUAD_STRIP: begin
                if (asm_phase == 3) begin
                    tris[0]     = corners(held_idx[0], held_idx[1], v);
                    tris[1]     = corners(held_idx[0], v, held_idx[2]);
                    n = 2;
                    held_idx[0] = held_idx[2];
                    held_idx[1] = v;
                    asm_phase   = 2;
                end else begin
                    held_idx[asm_phase] = v;
                    asm_phase++;
                end
            end
            default: ;
        endcase
        if (n > 0)
            tris[n-1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++)
            tri_expect_q = {tri_expect_q, tris[k]};
        if (it.end_of_set) begin
            asm_phase = 0;
            strip_odd = 1'b0;
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        mismatch_count++;
    endtask

    task automatic check_triangle(input t_tri got);
        t_tri want;
        if (tri_expect_q.size() == 0) begin
            $display("%0t: unexpected triangle, expected none, actual %h %h %h last %b",
                     $time, got.corner_a, got.corner_b, got.corner_c, got.last_of_run);
            mismatch_count++;
        end else begin
            want = tri_expect_q.pop_front();
            if (want.corner_a !== got.corner_a)
                report_field("corner_a", want.corner_a, got.corner_a);
            if (want.corner_b !== got.corner_b)
                report_field("corner_b", want.corner_b, got.corner_b);
            if (want.corner_c !== got.corner_c)
                report_field("corner_c", want.corner_c, got.corner_c);
            if (want.last_of_run !== got.last_of_run)
                report_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        end
    endtask

    // Index driver: hold valid and payload until transfer, insert idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_triangles(i_in_item);
                accepted_count++;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the current transfer
            end else if (drv_gap > 0) begin
                drv_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_idx_q.size() > 0) begin
                if (!calm && $urandom_range(99) < drv_idle_pct) begin
                    drv_gap = $urandom_range(12, 1) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_item  <= pending_idx_q.pop_front();
                    i_in_valid <= 1'b1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Triangle monitor: check each output transfer, stall ready in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rcv_gap = 0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_triangle(o_out_item);
            if (rcv_gap > 0) begin
                rcv_gap--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(99) < rcv_stall_pct) begin
                rcv_gap = $urandom_range(12, 1) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any transfer on any port restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_index(input logic [31:0] v, input logic eos);
        t_in_item it;
        it.vertex_index = v;
        it.end_of_set   = eos;
        pending_idx_q = {pending_idx_q, it};
        issued_count++;
    endtask

    // Wait until every queued index is taken and every owed triangle has come out
    task automatic drain();
        while (accepted_count != issued_count || tri_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the mode only with the core idle; the write also restarts the set
    task automatic write_mode(input logic [2:0] m);
        drain();
        repeat (PIPE_SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        asm_mode  = m;
        asm_phase = 0;
        strip_odd = 1'b0;
    endtask

    function automatic logic [31:0] pick_index();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    // Well-formed lengths complete whole primitives; the rest are random and may leave leftovers
    function automatic int set_length(input logic [2:0] m, input bit well_formed);
        if (!well_formed)
            return $urandom_range(8, 1);
        case (m)
            MODE_TRIANGLES:  return 3 * $urandom_range(3, 1);
            MODE_QUADS:      return 4 * $urandom_range(2, 1);
            MODE_QUAD_STRIP: return 2 * $urandom_range(5, 2);
            MODE_STRIP, MODE_FAN, MODE_POLYGON: return $urandom_range(9, 3);
            default:         return $urandom_range(6, 1);
        endcase
    endfunction

    initial begin : stimulus
        logic [2:0] mode_pool [8];
        logic [2:0] m;
        int         phase_no;
        int         random_count;
        int         sets;
        int         len;
        int         pool_pick;
        bit         open_tail;

        mode_pool = '{MODE_TRIANGLES, MODE_STRIP, MODE_FAN, MODE_POLYGON,
                      MODE_QUADS, MODE_QUAD_STRIP, MODE_SPARE_LO, MODE_SPARE_HI};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: triangle list with extreme indices; the trailing lone index is dropped
        write_mode(MODE_TRIANGLES);
        push_index(32'h0000_0000, 1'b0);
        push_index(32'hFFFF_FFFF, 1'b0);
        push_index(32'hAAAA_AAAA, 1'b0);
        push_index(32'h5555_5555, 1'b1);

        // Strip: three triangles, the middle one has its first corners swapped
        write_mode(MODE_STRIP);
        push_index(32'd10, 1'b0);
        push_index(32'd11, 1'b0);
        push_index(32'd12, 1'b0);
        push_index(32'd13, 1'b0);
        push_index(32'd14, 1'b1);

        // Fan pivots on the first index of the set
        write_mode(MODE_FAN);
        push_index(32'd20, 1'b0);
        push_index(32'd21, 1'b0);
        push_index(32'd22, 1'b0);
        push_index(32'd23, 1'b1);

        write_mode(MODE_POLYGON);
        push_index(32'hFFFF_FFF0, 1'b0);
        push_index(32'd31, 1'b0);
        push_index(32'd32, 1'b1);

        // One quad gives two triangles from a single index
        write_mode(MODE_QUADS);
        push_index(32'd40, 1'b0);
        push_index(32'd41, 1'b0);
        push_index(32'd42, 1'b0);
        push_index(32'd43, 1'b1);

        // Quad strip left open: the following mode write must restart the set
        write_mode(MODE_QUAD_STRIP);
        push_index(32'd50, 1'b0);
        push_index(32'd51, 1'b0);
        push_index(32'd52, 1'b0);
        push_index(32'd53, 1'b0);
        push_index(32'd54, 1'b0);
        push_index(32'd55, 1'b0);

        // Unknown code: indices are taken but yield nothing
        write_mode(MODE_SPARE_HI);
        push_index(32'd60, 1'b0);
        push_index(32'd61, 1'b1);

        // Random phases: walk every code once, then pick modes with spares less likely
        phase_no     = 0;
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            if (phase_no < 8) begin
                m = mode_pool[phase_no];
            end else begin
                pool_pick = $urandom_range(13);
                if (pool_pick >= 8)
                    pool_pick -= 8;
                m = mode_pool[pool_pick];
            end
            write_mode(m);

            case ($urandom_range(2))
                0:       drv_idle_pct = 0;
                1:       drv_idle_pct = 10;
                default: drv_idle_pct = 35;
            endcase
            case ($urandom_range(2))
                0:       rcv_stall_pct = 0;
                1:       rcv_stall_pct = 10;
                default: rcv_stall_pct = 35;
            endcase

            sets      = $urandom_range(6, 2);
            open_tail = ($urandom_range(99) < 15);
            for (int s = 0; s < sets; s++) begin
                len = set_length(m, $urandom_range(99) < 85);
                for (int j = 0; j < len; j++) begin
                    push_index(pick_index(),
                               (j == len - 1) && !(open_tail && s == sets - 1));
                    random_count++;
                end
                // Once, hold the index stream until the core has caught up
                if (phase_no == 9 && s == 0)
                    drain();
                if (random_count >= CALM_AFTER)
                    calm = 1'b1;
            end
            phase_no++;
        end

        drain();
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && tri_expect_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
